@@ rtl/core/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion helpers, clocked on clock, off during reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/pct_pkg.sv @@
// ---------------------------------------------------------------------------
// pct_pkg
// shared types, codes and helpers of the pair cooldown table
// ---------------------------------------------------------------------------
package pct_pkg;

   localparam int TABLE_DEPTH_DEF  = 64;
   localparam int PURGE_PERIOD_DEF = 60;
   localparam int QUEUE_DEPTH      = 2;

   localparam int KEY_W   = 32;
   localparam int FRAME_W = 32;
   localparam int ID_W    = 16;
   localparam int DUR_W   = 12;
   localparam int OP_W    = 2;

   // request codes
   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
   localparam logic [OP_W-1:0] OP_SET   = 2'd2;

   // classified item passed from front to back
   typedef struct packed {
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      logic [DUR_W-1:0] dur;
   } pct_item_type;

   // wrap-aware liveness: expiry - frame in 1 .. 2^31-1
   function automatic logic pct_live(input logic [FRAME_W-1:0] expiry,
                                     input logic [FRAME_W-1:0] frame);
      logic [FRAME_W-1:0] d;
      d = expiry - frame;
      return (d != '0) && !d[FRAME_W-1];
   endfunction

endpackage

@@ rtl/core/pct_ram.sv @@
// ---------------------------------------------------------------------------
// pct_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
module pct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/pct_front.sv @@
// ---------------------------------------------------------------------------
// pct_front
// takes request items, forms the pair key and pushes them to the queue
// ---------------------------------------------------------------------------
module pct_front
   import pct_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_type,
   input  logic [ID_W-1:0]  req_id_first,
   input  logic [ID_W-1:0]  req_id_second,
   input  logic [DUR_W-1:0] req_duration,
   input  logic             q_full,
   output logic             q_push,
   output pct_item_type     q_item
);

   logic             hold_valid_ff, hold_valid_in;
   logic [OP_W-1:0]  op_ff;
   logic [ID_W-1:0]  ida_ff, idb_ff;
   logic [DUR_W-1:0] dur_ff;
   logic [ID_W-1:0]  lo, hi;
   logic [KEY_W-1:0] sq;
   logic             accept;

   assign busy   = hold_valid_ff && q_full;
   assign accept = start && !busy;
   assign q_push = hold_valid_ff && !q_full;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_type;
         ida_ff <= req_id_first;
         idb_ff <= req_id_second;
         dur_ff <= req_duration;
      end
   end

   // szudzik pairing of the ordered ids
   always_comb begin
      lo = (ida_ff < idb_ff) ? ida_ff : idb_ff;
      hi = (ida_ff < idb_ff) ? idb_ff : ida_ff;
      sq = KEY_W'(hi) * KEY_W'(hi);
      q_item.op  = op_ff;
      q_item.key = sq + KEY_W'(hi) + KEY_W'(lo);
      q_item.dur = dur_ff;
   end

endmodule

@@ rtl/core/pct_queue.sv @@
// ---------------------------------------------------------------------------
// pct_queue
// short fifo decoupling the front from the table engine
// ---------------------------------------------------------------------------
module pct_queue
   import pct_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  pct_item_type push_item,
   output logic         full,
   output logic         valid,
   input  logic         pop,
   output pct_item_type head_item
);

   localparam int PtrW = $clog2(QUEUE_DEPTH);

   pct_item_type            entry_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [PtrW:0]           count_ff, count_in;

   assign full      = (count_ff == (PtrW+1)'(QUEUE_DEPTH));
   assign valid     = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ rtl/core/pct_back.sv @@
// ---------------------------------------------------------------------------
// pct_back
// table engine: frame counter, slot scan over the key and expiry rams
// ---------------------------------------------------------------------------
module pct_back
   import pct_pkg::*;
#(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int PURGE_PERIOD = PURGE_PERIOD_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_pop,
   input  pct_item_type q_item,
   output logic         rsp_strobe,
   output logic         rsp_on_cooldown,
   output logic         rsp_dropped
);

   localparam int IdxW = $clog2(TABLE_DEPTH);
   localparam int PhW  = (PURGE_PERIOD > 1) ? $clog2(PURGE_PERIOD) : 1;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [OP_W-1:0]        op_ff, op_in;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [FRAME_W-1:0]     exp_new_ff, exp_new_in;
   logic [FRAME_W-1:0]     frame_ff, frame_in, frame_inc;
   logic [PhW-1:0]         phase_ff, phase_in, phase_next;
   logic [IdxW:0]          rd_cnt_ff, rd_cnt_in;
   logic                   cmp_valid_ff, cmp_valid_in;
   logic [IdxW-1:0]        cmp_idx_ff, cmp_idx_in;
   logic                   hit_ff, hit_in;
   logic                   done_ff, done_in;
   logic                   free_found_ff, free_found_in;
   logic [IdxW-1:0]        free_idx_ff, free_idx_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                   strobe_ff, strobe_in;
   logic                   hit_out_ff, hit_out_in;
   logic                   drop_ff, drop_in;

   logic                   rd_en;
   logic [IdxW-1:0]        rd_addr;
   logic [KEY_W-1:0]       key_rd;
   logic [FRAME_W-1:0]     exp_rd;
   logic                   key_wr_en, exp_wr_en;
   logic [IdxW-1:0]        exp_wr_addr;
   logic                   slot_v, slot_match, slot_live;

   pct_ram #(.WIDTH(KEY_W), .DEPTH(TABLE_DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (free_idx_ff),
      .wr_data (key_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   pct_ram #(.WIDTH(FRAME_W), .DEPTH(TABLE_DEPTH)) u_exp_ram (
      .clock   (clock),
      .wr_en   (exp_wr_en),
      .wr_addr (exp_wr_addr),
      .wr_data (exp_new_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (exp_rd)
   );

   assign frame_inc = frame_ff + 1'b1;

   // frame modulo period, realigned when the counter wraps to zero
   always_comb begin
      if (frame_inc == '0) begin
         phase_next = '0;
      end else if (phase_ff == PhW'(PURGE_PERIOD-1)) begin
         phase_next = '0;
      end else begin
         phase_next = phase_ff + 1'b1;
      end
   end

   assign slot_v     = valid_ff[cmp_idx_ff];
   assign slot_match = (key_rd == key_ff);
   assign slot_live  = pct_live(exp_rd, frame_ff);

   assign q_pop = (state_ff == ST_IDLE) && q_valid;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      exp_new_in    = exp_new_ff;
      frame_in      = frame_ff;
      phase_in      = phase_ff;
      rd_cnt_in     = rd_cnt_ff;
      cmp_valid_in  = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      hit_in        = hit_ff;
      done_in       = done_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      strobe_in     = 1'b0;
      hit_out_in    = 1'b0;
      drop_in       = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = rd_cnt_ff[IdxW-1:0];
      key_wr_en     = 1'b0;
      exp_wr_en     = 1'b0;
      exp_wr_addr   = cmp_idx_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               op_in         = q_item.op;
               key_in        = q_item.key;
               exp_new_in    = frame_ff + FRAME_W'(q_item.dur);
               rd_cnt_in     = '0;
               hit_in        = 1'b0;
               done_in       = 1'b0;
               free_found_in = 1'b0;
               case (q_item.op)
                  OP_TICK: begin
                     frame_in = frame_inc;
                     phase_in = phase_next;
                     if (phase_next == '0) begin
                        state_in = ST_SCAN;
                     end else begin
                        strobe_in = 1'b1;
                     end
                  end
                  OP_QUERY, OP_SET: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rd_cnt_ff < (IdxW+1)'(TABLE_DEPTH)) begin
               rd_en        = 1'b1;
               rd_cnt_in    = rd_cnt_ff + 1'b1;
               cmp_valid_in = 1'b1;
               cmp_idx_in   = rd_cnt_ff[IdxW-1:0];
            end
            if (cmp_valid_ff) begin
               case (op_ff)
                  OP_TICK: begin
                     if (slot_v && !slot_live) begin
                        valid_in[cmp_idx_ff] = 1'b0;
                     end
                  end
                  OP_QUERY: begin
                     if (slot_v && slot_match && slot_live) begin
                        hit_in = 1'b1;
                     end
                  end
                  OP_SET: begin
                     if (slot_v && slot_match && !done_ff) begin
                        exp_wr_en = 1'b1;
                        done_in   = 1'b1;
                     end
                     if (!slot_v && !free_found_ff) begin
                        free_found_in = 1'b1;
                        free_idx_in   = cmp_idx_ff;
                     end
                  end
                  default: begin
                  end
               endcase
               if (cmp_idx_ff == IdxW'(TABLE_DEPTH-1)) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            strobe_in  = 1'b1;
            hit_out_in = (op_ff == OP_QUERY) && hit_ff;
            if (op_ff == OP_SET && !done_ff) begin
               if (free_found_ff) begin
                  key_wr_en             = 1'b1;
                  exp_wr_en             = 1'b1;
                  exp_wr_addr           = free_idx_ff;
                  valid_in[free_idx_ff] = 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         phase_ff     <= '0;
         valid_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         strobe_ff    <= 1'b0;
         hit_out_ff   <= 1'b0;
         drop_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         phase_ff     <= phase_in;
         valid_ff     <= valid_in;
         cmp_valid_ff <= cmp_valid_in;
         strobe_ff    <= strobe_in;
         hit_out_ff   <= hit_out_in;
         drop_ff      <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      exp_new_ff    <= exp_new_in;
      rd_cnt_ff     <= rd_cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      done_ff       <= done_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_on_cooldown = hit_out_ff;
   assign rsp_dropped     = drop_ff;

endmodule

@@ rtl/core/pair_cooldown_table.sv @@
// ---------------------------------------------------------------------------
// pair_cooldown_table
// table of unordered id pairs with wrap-aware expiry frames and aging
// ---------------------------------------------------------------------------
// Requests are taken when start is high and busy is low; every request gives
// exactly one result, shown for a single cycle with rsp_strobe high, and the
// receiver cannot stall it, so it must take each result when it appears.
// A query, a set, or a tick that lands on a purge frame (every PURGE_PERIOD
// frames) walks all TABLE_DEPTH slots through the single read port of the
// key and expiry rams. Plain ticks and unknown request codes skip the scan.
// The queue holds two items, so a burst is absorbed and busy rises only
// when the front holding register and the queue are all occupied.
`include "assert_macros.svh"

module pair_cooldown_table
   import pct_pkg::*;
#(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int PURGE_PERIOD = PURGE_PERIOD_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request item
   input  logic             start,
   output logic             busy,
   input  logic [OP_W-1:0]  req_type,
   input  logic [ID_W-1:0]  req_id_first,
   input  logic [ID_W-1:0]  req_id_second,
   input  logic [DUR_W-1:0] req_duration,
   // result item, one cycle strobe
   output logic             rsp_strobe,
   output logic             rsp_on_cooldown,
   output logic             rsp_dropped
);

   // front to queue
   logic         q_push;
   logic         q_full;
   pct_item_type push_item;

   // queue to engine
   logic         q_valid;
   logic         q_pop;
   pct_item_type head_item;

   // front: latch the request and form the szudzik key
   pct_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_type      (req_type),
      .req_id_first  (req_id_first),
      .req_id_second (req_id_second),
      .req_duration  (req_duration),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_item        (push_item)
   );

   // short fifo so the front keeps taking items while a scan runs
   pct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .valid     (q_valid),
      .pop       (q_pop),
      .head_item (head_item)
   );

   // engine: frame counter, purge, lookup and insert over the slot rams
   pct_back #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .PURGE_PERIOD (PURGE_PERIOD)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_item          (head_item),
      .rsp_strobe      (rsp_strobe),
      .rsp_on_cooldown (rsp_on_cooldown),
      .rsp_dropped     (rsp_dropped)
   );

   // no push into a full queue, no pop from an empty one
   `ASSERT_SAME(a_no_overflow, q_push, !q_full, "push into full queue")
   `ASSERT_SAME(a_no_underflow, q_pop, q_valid, "pop from empty queue")
   // a pushed item is waiting in the queue on the next cycle
   `ASSERT_NEXT(a_push_lands, q_push, q_valid, "pushed item missing from queue")
   // a result is either a hit or a drop, never both
   `ASSERT_SAME(a_one_flag, rsp_strobe, !(rsp_on_cooldown && rsp_dropped), "hit and drop")
   // flags only ever move with the strobe
   `ASSERT_SAME(a_flags_quiet, !rsp_strobe, !rsp_on_cooldown && !rsp_dropped, "stray flag")

endmodule
